// File: sv/sts_pkg.sv
// shared types and constants for the sphere triangle subdivider
package sts_pkg;
	localparam int FRAC_BITS  = 14;
	localparam int MAX_LEVEL  = 3;
	localparam int COORD_W    = 16;
	localparam int LEVEL_W    = 2;
	// squared sum of three halved 16 bit values fits in 32 bits
	localparam int SQ_W       = 32;
	localparam int ROOT_W     = SQ_W / 2;
	localparam int MAG_W      = COORD_W;
	localparam int NUM_W      = MAG_W + FRAC_BITS + 1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef struct packed {
		coord_t z;
		coord_t y;
		coord_t x;
	} vec3_t;
	typedef struct packed {
		vec3_t c;
		vec3_t b;
		vec3_t a;
	} tri_t;

	typedef struct packed {
		logic  start;
		vec3_t p;
		vec3_t q;
	} nrm_req_t;
endpackage

// File: sv/sts_normalize.sv
// midpoint of two vertices scaled to unit length, bit-serial root and divide
module sts_normalize (
	input  logic              clk,
	input  logic              arst_n,
	input  sts_pkg::nrm_req_t req,
	output logic              done,
	output sts_pkg::vec3_t    result
);
	import sts_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ   = 3'd1;
	localparam logic [2:0] ST_ROOT = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]          state_q;
	coord_t              m_q [3];
	logic [1:0]          comp_q;
	logic [5:0]          cnt_q;
	logic [SQ_W-1:0]     acc_q;
	logic [SQ_W-1:0]     mcand_q;
	logic [MAG_W-1:0]    mplier_q;
	logic [SQ_W+1:0]     rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [NUM_W-1:0]    num_q;
	logic [NUM_W:0]      drem_q;
	logic [NUM_W-1:0]    quo_q;

	logic signed [COORD_W:0] sum_v [3];
	coord_t                  half_v [3];
	logic [MAG_W-1:0]        mag_v;
	logic [SQ_W+1:0]         trial_v;
	logic [SQ_W+1:0]         rem_sh_v;
	logic [NUM_W:0]          drem_sh_v;
	logic [NUM_W-1:0]        qv_v;
	coord_t                  sat_v;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum_v[k] = (k == 0) ? ({req.p.x[COORD_W-1], req.p.x} + {req.q.x[COORD_W-1], req.q.x})
			         : (k == 1) ? ({req.p.y[COORD_W-1], req.p.y} + {req.q.y[COORD_W-1], req.q.y})
			         :            ({req.p.z[COORD_W-1], req.p.z} + {req.q.z[COORD_W-1], req.q.z});
			// arithmetic shift gives floor of the half sum
			half_v[k] = sum_v[k][COORD_W:1];
		end
		mag_v     = m_q[comp_q][COORD_W-1] ? MAG_W'(-m_q[comp_q]) : MAG_W'(m_q[comp_q]);
		rem_sh_v  = {rem_q[SQ_W-1:0], acc_q[SQ_W-1 -: 2]};
		trial_v   = {{(SQ_W+2-ROOT_W-2){1'b0}}, root_q, 2'b01};
		drem_sh_v = {drem_q[NUM_W-1:0], num_q[NUM_W-1]};
		qv_v      = quo_q;
		if (qv_v > NUM_W'(1 << FRAC_BITS)) qv_v = NUM_W'(1 << FRAC_BITS);
		sat_v     = m_q[comp_q][COORD_W-1] ? coord_t'(-qv_v[COORD_W-1:0]) : coord_t'(qv_v[COORD_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			comp_q  <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						state_q <= ST_SQ;
						comp_q  <= '0;
						cnt_q   <= '0;
					end
				end
				ST_SQ: begin
					// one multiplier bit a cycle per component
					if (cnt_q == 6'(MAG_W - 1)) begin
						cnt_q <= '0;
						if (comp_q == 2'd2) begin
							comp_q  <= '0;
							state_q <= ST_ROOT;
						end else begin
							comp_q <= comp_q + 2'd1;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_ROOT: begin
					if (cnt_q == 6'(ROOT_W - 1)) begin
						cnt_q   <= '0;
						state_q <= (acc_q == '0 && root_q == '0 && rem_sh_v < trial_v)
						           ? ST_DONE : ST_DIV;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_DIV: begin
					if (cnt_q == 6'(NUM_W)) begin
						cnt_q <= '0;
						if (comp_q == 2'd2) begin
							comp_q  <= '0;
							state_q <= ST_DONE;
						end else begin
							comp_q <= comp_q + 2'd1;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				for (int k = 0; k < 3; k++) m_q[k] <= half_v[k];
				acc_q    <= '0;
				rem_q    <= '0;
				root_q   <= '0;
			end
			ST_SQ: begin
				if (cnt_q == '0) begin
					mcand_q  <= SQ_W'(mag_v) << 1;
					mplier_q <= mag_v >> 1;
					if (mag_v[0]) acc_q <= acc_q + SQ_W'(mag_v);
				end else begin
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					if (mplier_q[0]) acc_q <= acc_q + mcand_q;
				end
			end
			ST_ROOT: begin
				// one result bit a cycle, two radicand bits taken in
				acc_q <= acc_q << 2;
				if (rem_sh_v >= trial_v) begin
					rem_q  <= rem_sh_v - trial_v;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh_v;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
				if (cnt_q == 6'(ROOT_W - 1)) begin
					num_q  <= (NUM_W'(mag_v) << FRAC_BITS) + NUM_W'({1'b0, root_q[ROOT_W-2:0], (rem_sh_v >= trial_v)} >> 1);
					drem_q <= '0;
					quo_q  <= '0;
				end
			end
			ST_DIV: begin
				if (cnt_q == 6'(NUM_W)) begin
					m_q[comp_q] <= sat_v;
					num_q  <= (NUM_W'(m_q[comp_q + 2'd1][COORD_W-1]
					          ? MAG_W'(-m_q[comp_q + 2'd1]) : MAG_W'(m_q[comp_q + 2'd1])) << FRAC_BITS)
					          + NUM_W'(root_q >> 1);
					drem_q <= '0;
					quo_q  <= '0;
				end else begin
					num_q <= num_q << 1;
					if (drem_sh_v >= (NUM_W+1)'(root_q)) begin
						drem_q <= drem_sh_v - (NUM_W+1)'(root_q);
						quo_q  <= {quo_q[NUM_W-2:0], 1'b1};
					end else begin
						drem_q <= drem_sh_v;
						quo_q  <= {quo_q[NUM_W-2:0], 1'b0};
					end
				end
			end
			default: ;
		endcase
	end

	assign done     = (state_q == ST_DONE);
	assign result.x = m_q[0];
	assign result.y = m_q[1];
	assign result.z = m_q[2];

	a_done_one: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQ) |-> (comp_q != 2'd3)) else $error("component overrun");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_DIV || state_q == ST_ROOT)) else $error("bad done");
endmodule

// File: sv/sphere_triangle_subdivider.sv
// recursive triangle splitter with unit-sphere midpoints
// a normalization steps through start, multiply steps for each component, root
// steps, divide steps for each component and done; a zero-length midpoint skips the divide
// each child triangle needs three; level L builds 4 + .. + 4^L children, so 252
// normalizations per item at level 3 and none at level 0
// one item at a time; a new item is taken once its last leaf is in the output register
// asynchronous active-low reset clears control, level and the output valid and last flags
module sphere_triangle_subdivider (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata,     // subdivision_level [1:0]
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,  // a_x a_y a_z b_x b_y b_z c_x c_y c_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [143:0] m_axis_tdata,  // leaf_a_x .. leaf_c_z
	output logic         m_axis_tlast   // last_leaf
);
	import sts_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DECIDE= 3'd1;
	localparam logic [2:0] ST_NORM  = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;
	localparam logic [2:0] ST_UP    = 3'd5;

	logic [2:0]        state_q;
	logic [LEVEL_W-1:0] level_q;
	logic [LEVEL_W-1:0] depth_q;
	logic [1:0]        pos_q [MAX_LEVEL];
	tri_t              tri_q [MAX_LEVEL+1];
	vec3_t             mid_q [3];
	logic [1:0]        nsel_q;
	logic              last_q;
	logic              out_valid_q;
	tri_t              out_tri_q;

	nrm_req_t req;
	logic     ndone;
	vec3_t    nres;
	tri_t     cur;
	logic     all_last;

	assign cur = tri_q[depth_q];

	always_comb begin
		req.start = (state_q == ST_NORM);
		unique case (nsel_q)
			2'd0:    begin req.p = cur.a; req.q = cur.b; end
			2'd1:    begin req.p = cur.b; req.q = cur.c; end
			default: begin req.p = cur.c; req.q = cur.a; end
		endcase
		all_last = 1'b1;
		for (int d = 0; d < MAX_LEVEL; d++)
			if (LEVEL_W'(d) < level_q && pos_q[d] != 2'd3) all_last = 1'b0;
	end

	sts_normalize u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.done   (ndone),
		.result (nres)
	);

	assign s_axis_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			level_q     <= '0;
			depth_q     <= '0;
			nsel_q      <= '0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
			for (int d = 0; d < MAX_LEVEL; d++) pos_q[d] <= '0;
		end else begin
			if (cfg_we) level_q <= cfg_wdata[LEVEL_W-1:0];
			if (state_q == ST_EMIT && (!out_valid_q || m_axis_tready))
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						depth_q <= '0;
						for (int d = 0; d < MAX_LEVEL; d++) pos_q[d] <= '0;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (depth_q >= level_q) begin
						state_q <= ST_EMIT;
					end else begin
						nsel_q  <= '0;
						state_q <= ST_NORM;
					end
				end
				ST_NORM: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (ndone) begin
						if (nsel_q == 2'd2) begin
							depth_q <= depth_q + 2'd1;
							state_q <= ST_DECIDE;
						end else begin
							nsel_q  <= nsel_q + 2'd1;
							state_q <= ST_NORM;
						end
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || m_axis_tready) begin
						last_q      <= all_last;
						state_q     <= all_last ? ST_IDLE : ST_UP;
					end
				end
				ST_UP: begin
					// climb to the nearest depth with a sibling left
					if (pos_q[depth_q - 2'd1] == 2'd3) begin
						pos_q[depth_q - 2'd1] <= '0;
						depth_q <= depth_q - 2'd1;
					end else begin
						pos_q[depth_q - 2'd1] <= pos_q[depth_q - 2'd1] + 2'd1;
						depth_q <= depth_q - 2'd1;
						nsel_q  <= '0;
						state_q <= ST_NORM;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) tri_q[0] <= s_axis_tdata;
		if (state_q == ST_WAIT && ndone) begin
			mid_q[nsel_q] <= nres;
			if (nsel_q == 2'd2) begin
				unique case (pos_q[depth_q[1:0] == 2'd3 ? 2'd2 : depth_q])
					2'd0: tri_q[depth_q + 2'd1] <= '{a: cur.a,    b: mid_q[0], c: nres};
					2'd1: tri_q[depth_q + 2'd1] <= '{a: mid_q[0], b: cur.b,    c: mid_q[1]};
					2'd2: tri_q[depth_q + 2'd1] <= '{a: nres,     b: mid_q[0], c: mid_q[1]};
					default: tri_q[depth_q + 2'd1] <= '{a: cur.c, b: nres,     c: mid_q[1]};
				endcase
			end
		end
		if (state_q == ST_EMIT && (!out_valid_q || m_axis_tready)) out_tri_q <= cur;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_tri_q;
	assign m_axis_tlast  = last_q;

	a_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_DECIDE)) else $error("accept lost");
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (depth_q >= level_q)) else $error("leaf too shallow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
		else $error("output item changed while waiting");
endmodule
